// File: hw/rtl/ipc_pkg.sv
package ipc_pkg;

  localparam int QUERY_W = 9;
  localparam int COUNT_W = 64;

  localparam logic [COUNT_W-1:0] COUNT_ONES = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

  typedef struct packed {
    logic clear;
    logic valid;
    logic second;
    logic negate;
  } acc_ctrl_t;

  typedef struct packed {
    logic               stop;
    logic [COUNT_W-1:0] stop_value;
    logic [COUNT_W-1:0] acc;
  } acc_stat_t;

endpackage

// File: hw/rtl/ipc_query_if.sv
interface ipc_query_if import ipc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [QUERY_W-1:0] query_n;

  modport source (output valid, output query_n, input ready);
  modport sink (input valid, input query_n, output ready);
endinterface

// File: hw/rtl/ipc_result_if.sv
interface ipc_result_if import ipc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic               saturated;

  modport source (output valid, output count, output saturated, input ready);
  modport sink (input valid, input count, input saturated, output ready);
endinterface

// File: hw/rtl/ipc_acc.sv
module ipc_acc import ipc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acc_ctrl_t          ctrl_i,
  input  logic [COUNT_W-1:0] term_i,
  output acc_stat_t          stat_o
);

  logic [COUNT_W-1:0] acc_q, acc_d;
  logic               ones1_q, ones1_d;
  logic               fail1_q, fail1_d;
  logic               failones1_q, failones1_d;
  logic [COUNT_W:0]   op_res;
  logic               op_fail;
  logic               term_ones;

  assign op_res    = ctrl_i.negate ? ({1'b0, acc_q} - {1'b0, term_i})
                                   : ({1'b0, acc_q} + {1'b0, term_i});
  assign op_fail   = op_res[COUNT_W];
  assign term_ones = (term_i == COUNT_ONES);

  always_comb begin
    acc_d             = acc_q;
    ones1_d           = ones1_q;
    fail1_d           = fail1_q;
    failones1_d       = failones1_q;
    stat_o.stop       = 1'b0;
    stat_o.stop_value = '0;
    stat_o.acc        = acc_q;
    if (ctrl_i.clear) begin
      acc_d       = '0;
      ones1_d     = 1'b0;
      fail1_d     = 1'b0;
      failones1_d = 1'b0;
    end else if (ctrl_i.valid && !ctrl_i.second) begin
      ones1_d     = term_ones;
      fail1_d     = op_fail;
      failones1_d = !ctrl_i.negate;
      if (!op_fail) begin
        acc_d = op_res[COUNT_W-1:0];
      end
    end else if (ctrl_i.valid) begin
      // either term saturated wins over any earlier failure
      if (ones1_q || term_ones) begin
        stat_o.stop       = 1'b1;
        stat_o.stop_value = COUNT_ONES;
      end else if (fail1_q) begin
        stat_o.stop       = 1'b1;
        stat_o.stop_value = failones1_q ? COUNT_ONES : '0;
      end else if (op_fail) begin
        stat_o.stop       = 1'b1;
        stat_o.stop_value = ctrl_i.negate ? '0 : COUNT_ONES;
      end else begin
        acc_d = op_res[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones1_q     <= 1'b0;
      fail1_q     <= 1'b0;
      failones1_q <= 1'b0;
    end else begin
      ones1_q     <= ones1_d;
      fail1_q     <= fail1_d;
      failones1_q <= failones1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// File: hw/rtl/integer_partition_count.sv
// query for an entry already in the table: table read, then the result register, then the output register once free
// query at or beyond the table depth: count all ones and saturated set
// each missing entry m is built first, in order up to the query, through the single
// table read port (one earlier entry read per cycle while building)
// one query at a time; a new query is taken while the previous result waits on the output
// reset clears control state; table contents stay undefined, entry 0 reads as one, no clear pass
module integer_partition_count import ipc_pkg::*; #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ipc_query_if.sink    query_i,
  ipc_result_if.source result_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OW = AW + 2;
  localparam int NW = (AW + 1 > QUERY_W) ? AW + 1 : QUERY_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_BUILD  = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      filled_q, filled_d;
  logic [AW-1:0]      n_q, n_d;
  logic [AW-1:0]      m_q, m_d;
  logic [OW-1:0]      k_q, k_d;
  logic [OW-1:0]      off1_q, off1_d;
  logic               sec_q, sec_d;
  logic               issue_done_q, issue_done_d;
  logic               pipe_vld_q, pipe_vld_d;
  logic               pipe_sec_q, pipe_sec_d;
  logic               pipe_neg_q, pipe_neg_d;
  logic               pipe_zero_q, pipe_zero_d;
  logic               pipe_one_q, pipe_one_d;
  logic [COUNT_W-1:0] ent_q, ent_d;
  logic [COUNT_W-1:0] res_q, res_d;
  logic               out_vld_q, out_vld_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_sat_q, out_sat_d;

  logic [COUNT_W-1:0] mem [TABLE_DEPTH];
  logic [COUNT_W-1:0] rd_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic [NW-1:0]      n_ext;
  logic [AW-1:0]      n_addr;
  logic               beyond;
  logic               in_xfer;
  logic [OW-1:0]      m_ext;
  logic [OW-1:0]      off2;
  logic [OW-1:0]      addr_full;

  acc_ctrl_t          acc_ctrl;
  acc_stat_t          acc_stat;
  logic [COUNT_W-1:0] term;

  assign n_ext     = NW'(query_i.query_n);
  assign n_addr    = n_ext[AW-1:0];
  assign beyond    = (n_ext >= NW'(TABLE_DEPTH));
  assign query_i.ready = (state_q == S_IDLE);
  assign in_xfer   = query_i.valid && query_i.ready;
  assign m_ext     = OW'(m_q);
  assign off2      = off1_q + k_q;
  assign addr_full = m_ext - (sec_q ? off2 : off1_q);

  assign term = pipe_zero_q ? '0 : (pipe_one_q ? COUNT_ONE : rd_q);

  // accumulator restarts whenever a new entry build begins
  assign acc_ctrl.clear  = ((state_q == S_IDLE) && in_xfer && !beyond && (n_addr > filled_q))
                        || ((state_q == S_WRITE) && (m_q != n_q));
  assign acc_ctrl.valid  = pipe_vld_q && (state_q == S_BUILD);
  assign acc_ctrl.second = pipe_sec_q;
  assign acc_ctrl.negate = pipe_neg_q;

  ipc_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .term_i (term),
    .stat_o (acc_stat)
  );

  always_comb begin
    state_d        = state_q;
    filled_d       = filled_q;
    n_d            = n_q;
    m_d            = m_q;
    k_d            = k_q;
    off1_d         = off1_q;
    sec_d          = sec_q;
    issue_done_d   = issue_done_q;
    pipe_vld_d     = 1'b0;
    pipe_sec_d     = pipe_sec_q;
    pipe_neg_d     = pipe_neg_q;
    pipe_zero_d    = pipe_zero_q;
    pipe_one_d     = pipe_one_q;
    ent_d          = ent_q;
    res_d          = res_q;
    out_vld_d      = out_vld_q && !result_o.ready;
    out_count_d    = out_count_q;
    out_sat_d      = out_sat_q;
    rd_en          = 1'b0;
    rd_addr        = addr_full[AW-1:0];
    wr_en          = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_addr = n_addr;
        if (in_xfer) begin
          n_d = n_addr;
          if (beyond) begin
            res_d   = COUNT_ONES;
            state_d = S_RESULT;
          end else if (n_addr <= filled_q) begin
            rd_en   = 1'b1;
            state_d = S_LOOKUP;
          end else begin
            m_d            = filled_q + AW'(1);
            k_d            = OW'(1);
            off1_d         = OW'(1);
            sec_d          = 1'b0;
            issue_done_d   = 1'b0;
            state_d        = S_BUILD;
          end
        end
      end
      S_LOOKUP: begin
        res_d   = (n_q == '0) ? COUNT_ONE : rd_q;
        state_d = S_RESULT;
      end
      S_BUILD: begin
        if (acc_stat.stop) begin
          ent_d   = acc_stat.stop_value;
          state_d = S_WRITE;
        end else if (issue_done_q) begin
          if (!pipe_vld_q) begin
            ent_d   = acc_stat.acc;
            state_d = S_WRITE;
          end
        end else if (!sec_q) begin
          if (off1_q > m_ext) begin
            issue_done_d = 1'b1;
          end else begin
            rd_en       = 1'b1;
            pipe_vld_d  = 1'b1;
            pipe_sec_d  = 1'b0;
            pipe_neg_d  = !k_q[0];
            pipe_zero_d = 1'b0;
            pipe_one_d  = (addr_full == '0);
            sec_d       = 1'b1;
          end
        end else begin
          rd_en       = (off2 <= m_ext);
          pipe_vld_d  = 1'b1;
          pipe_sec_d  = 1'b1;
          pipe_neg_d  = !k_q[0];
          pipe_zero_d = (off2 > m_ext);
          pipe_one_d  = (addr_full == '0);
          sec_d       = 1'b0;
          k_d         = k_q + OW'(1);
          off1_d      = off1_q + (k_q << 1) + k_q + OW'(1);
        end
      end
      S_WRITE: begin
        wr_en    = 1'b1;
        filled_d = m_q;
        if (m_q == n_q) begin
          res_d   = ent_q;
          state_d = S_RESULT;
        end else begin
          m_d            = m_q + AW'(1);
          k_d            = OW'(1);
          off1_d         = OW'(1);
          sec_d          = 1'b0;
          issue_done_d   = 1'b0;
          state_d        = S_BUILD;
        end
      end
      S_RESULT: begin
        if (!out_vld_q || result_o.ready) begin
          out_vld_d   = 1'b1;
          out_count_d = res_q;
          out_sat_d   = (res_q == COUNT_ONES);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      filled_q     <= '0;
      issue_done_q <= 1'b0;
      sec_q        <= 1'b0;
      pipe_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      filled_q     <= filled_d;
      issue_done_q <= issue_done_d;
      sec_q        <= sec_d;
      pipe_vld_q   <= pipe_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    m_q         <= m_d;
    k_q         <= k_d;
    off1_q      <= off1_d;
    pipe_sec_q  <= pipe_sec_d;
    pipe_neg_q  <= pipe_neg_d;
    pipe_zero_q <= pipe_zero_d;
    pipe_one_q  <= pipe_one_d;
    ent_q       <= ent_d;
    res_q       <= res_d;
    out_count_q <= out_count_d;
    out_sat_q   <= out_sat_d;
  end

  // count table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[m_q] <= ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.count     = out_count_q;
  assign result_o.saturated = out_sat_q;

`ifndef NO_ASSERTIONS
  a_filled_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> filled_q >= $past(filled_q))
    else $error("table fill level went backward");

  a_write_next_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (m_q == filled_q + AW'(1)))
    else $error("table write not at the next entry");

  a_build_reads_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && state_q == S_BUILD) |-> (rd_addr < m_q))
    else $error("build read of an entry not yet written");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && !out_vld_q) |=> out_vld_q)
    else $error("result not loaded into free output register");
`endif

endmodule
